@@ rtl/hbsa_pkg.sv @@
// shared types, constants and the hilbert cell lookup for the scatter address block
`default_nettype none

package hbsa_pkg;

  // sizes
  localparam int MAX_LEVEL     = 8;
  localparam int COORD_BITS    = 12;
  localparam int LEVEL_BITS    = 4;
  localparam int SIDE_BITS     = COORD_BITS + 1;
  localparam int ADDR_BITS     = 24;
  localparam int BYTE_BITS     = 8;
  localparam int CELL_IDX_BITS = 2 * MAX_LEVEL;
  localparam int CELL_CNT_BITS = CELL_IDX_BITS + 1;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = SIDE_BITS;
  localparam int OUT_DATA_BITS = ((BYTE_BITS + ADDR_BITS + 2 * COORD_BITS + 7) / 8) * 8;

  localparam logic [SIDE_BITS-1:0]  SIDE_MAX  = SIDE_BITS'(1) << COORD_BITS;
  localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = LEVEL_BITS'(MAX_LEVEL);

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_CURVE_LEVEL = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_GRID_SIDE   = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CELL_SIDE   = 2'd2;

  // effective configuration seen by the datapath
  typedef struct packed {
    logic [LEVEL_BITS-1:0]    level;
    logic [SIDE_BITS-1:0]     cell_side;
    logic [CELL_CNT_BITS-1:0] cells;
    logic [SIDE_BITS-1:0]     grid_side;
  } cfg_eff_t;

  // cell coordinates
  typedef struct packed {
    logic [MAX_LEVEL-1:0] x;
    logic [MAX_LEVEL-1:0] y;
  } cell_xy_t;

  // item after the walk stage
  typedef struct packed {
    logic [BYTE_BITS-1:0]  data;
    logic [MAX_LEVEL-1:0]  cx;
    logic [MAX_LEVEL-1:0]  cy;
    logic [COORD_BITS-1:0] row;
    logic [COORD_BITS-1:0] col;
    logic                  last;
  } walk_t;

  // item after the placement stage
  typedef struct packed {
    logic [BYTE_BITS-1:0]  data;
    logic [COORD_BITS-1:0] gx;
    logic [COORD_BITS-1:0] gy;
    logic                  last;
  } place_t;

  // hilbert index to cell coordinates, first move along +y
  function automatic cell_xy_t hilbert_xy(input logic [LEVEL_BITS-1:0] level,
                                          input logic [CELL_IDX_BITS-1:0] d);
    logic [MAX_LEVEL-1:0] x;
    logic [MAX_LEVEL-1:0] y;
    logic [MAX_LEVEL-1:0] tmp;
    logic [MAX_LEVEL-1:0] msk;
    logic                 rx;
    logic                 ry;
    cell_xy_t             r;
    x   = '0;
    y   = '0;
    tmp = '0;
    msk = '0;
    rx  = 1'b0;
    ry  = 1'b0;
    for (int i = 0; i < MAX_LEVEL; i++) begin
      if (i < int'(level)) begin
        msk = MAX_LEVEL'((1 << i) - 1);
        rx  = d[2*i+1];
        ry  = d[2*i] ^ rx;
        if (!ry) begin
          if (rx) begin
            x = ~x & msk;
            y = ~y & msk;
          end
          tmp = x;
          x   = y;
          y   = tmp;
        end
        x[i] = rx;
        y[i] = ry;
      end
    end
    r.x = x;
    r.y = y;
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/hbsa_walk.sv @@
// position counters and hilbert cell lookup, first pipeline stage
`default_nettype none

module hbsa_walk (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire hbsa_pkg::cfg_eff_t             cfg,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [hbsa_pkg::BYTE_BITS-1:0] in_data,
  output logic                                walk_valid,
  input  wire logic                           walk_ready,
  output hbsa_pkg::walk_t                     walk
);
  import hbsa_pkg::*;

  logic [CELL_IDX_BITS-1:0] cell_idx_r, cell_idx_nxt;
  logic [COORD_BITS-1:0]    row_r, row_nxt;
  logic [COORD_BITS-1:0]    col_r, col_nxt;
  logic                     valid_r, valid_nxt;
  walk_t                    walk_r, walk_nxt;
  logic                     accept;
  logic                     col_wrap, row_wrap, cell_wrap;
  logic [CELL_IDX_BITS-1:0] cell_mask;
  cell_xy_t                 cxy;

  assign in_ready   = !valid_r || walk_ready;
  assign accept     = in_valid && in_ready;
  assign walk_valid = valid_r;
  assign walk       = walk_r;

  // wrap tests against the current limits
  assign col_wrap  = ({1'b0, col_r} + SIDE_BITS'(1)) >= cfg.cell_side;
  assign row_wrap  = ({1'b0, row_r} + SIDE_BITS'(1)) >= cfg.cell_side;
  assign cell_wrap = ({1'b0, cell_idx_r} + CELL_CNT_BITS'(1)) >= cfg.cells;
  assign cell_mask = CELL_IDX_BITS'(cfg.cells - CELL_CNT_BITS'(1));

  // cell of the current item
  assign cxy = hilbert_xy(cfg.level, cell_idx_r & cell_mask);

  // counter advance: column, then row, then cell
  always_comb begin
    cell_idx_nxt = cell_idx_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    if (accept) begin
      if (col_wrap) begin
        col_nxt = '0;
        if (row_wrap) begin
          row_nxt = '0;
          if (cell_wrap) begin
            cell_idx_nxt = '0;
          end else begin
            cell_idx_nxt = cell_idx_r + CELL_IDX_BITS'(1);
          end
        end else begin
          row_nxt = row_r + COORD_BITS'(1);
        end
      end else begin
        col_nxt = col_r + COORD_BITS'(1);
      end
    end
  end

  // stage register contents
  always_comb begin
    valid_nxt = valid_r;
    walk_nxt  = walk_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
    if (accept) begin
      walk_nxt.data = in_data;
      walk_nxt.cx   = cxy.x;
      walk_nxt.cy   = cxy.y;
      walk_nxt.row  = row_r;
      walk_nxt.col  = col_r;
      walk_nxt.last = col_wrap && row_wrap && cell_wrap;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_idx_r <= '0;
      row_r      <= '0;
      col_r      <= '0;
      valid_r    <= 1'b0;
    end else begin
      cell_idx_r <= cell_idx_nxt;
      row_r      <= row_nxt;
      col_r      <= col_nxt;
      valid_r    <= valid_nxt;
    end
  end

  // payload register
  always_ff @(posedge clk) begin
    walk_r <= walk_nxt;
  end

endmodule

`default_nettype wire

@@ rtl/hbsa_place.sv @@
// grid column and row from cell coordinates, second pipeline stage
`default_nettype none

module hbsa_place (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [hbsa_pkg::SIDE_BITS-1:0] cell_side,
  input  wire logic                       walk_valid,
  output logic                            walk_ready,
  input  wire hbsa_pkg::walk_t            walk,
  output logic                            place_valid,
  input  wire logic                       place_ready,
  output hbsa_pkg::place_t                place
);
  import hbsa_pkg::*;

  localparam int PROD_BITS = MAX_LEVEL + SIDE_BITS;

  logic                 valid_r, valid_nxt;
  place_t               place_r, place_nxt;
  logic [PROD_BITS-1:0] prod_x, prod_y;

  assign walk_ready  = !valid_r || place_ready;
  assign place_valid = valid_r;
  assign place       = place_r;

  // cell origin times cell side, wrapped to the coordinate width
  assign prod_x = PROD_BITS'(walk.cx) * PROD_BITS'(cell_side);
  assign prod_y = PROD_BITS'(walk.cy) * PROD_BITS'(cell_side);

  always_comb begin
    valid_nxt = valid_r;
    place_nxt = place_r;
    if (walk_ready) begin
      valid_nxt = walk_valid;
      if (walk_valid) begin
        place_nxt.data = walk.data;
        place_nxt.gx   = prod_x[COORD_BITS-1:0] + walk.col;
        place_nxt.gy   = prod_y[COORD_BITS-1:0] + walk.row;
        place_nxt.last = walk.last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    place_r <= place_nxt;
  end

endmodule

`default_nettype wire

@@ rtl/hbsa_addr.sv @@
// linear address and output register, last pipeline stage
`default_nettype none

module hbsa_addr (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic [hbsa_pkg::SIDE_BITS-1:0] grid_side,
  input  wire logic                           place_valid,
  output logic                                place_ready,
  input  wire hbsa_pkg::place_t               place,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [hbsa_pkg::OUT_DATA_BITS-1:0]  out_data,
  output logic                                out_last
);
  import hbsa_pkg::*;

  localparam int PROD_BITS = COORD_BITS + SIDE_BITS + 1;

  logic                     valid_r, valid_nxt;
  logic [OUT_DATA_BITS-1:0] data_r, data_nxt;
  logic                     last_r, last_nxt;
  logic [PROD_BITS-1:0]     addr_full;

  assign place_ready = !valid_r || out_ready;
  assign out_valid   = valid_r;
  assign out_data    = data_r;
  assign out_last    = last_r;

  // row times pitch plus column
  assign addr_full = PROD_BITS'(place.gy) * PROD_BITS'(grid_side) + PROD_BITS'(place.gx);

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    last_nxt  = last_r;
    if (place_ready) begin
      valid_nxt = place_valid;
      if (place_valid) begin
        data_nxt = OUT_DATA_BITS'({place.gy, place.gx,
                                   ADDR_BITS'(addr_full), place.data});
        last_nxt = place.last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    last_r <= last_nxt;
  end

endmodule

`default_nettype wire

@@ rtl/hilbert_block_scatter_addr.sv @@
// Three-register pipeline: counters and cell lookup share the walk stage, the two
// coordinate products sit in the place stage and the address product in the last.
// Throughput: one item per cycle while the output is ready.
// A stalled output holds the pipeline; input is taken while any stage can move.
// Reset: synchronous, active low; clears the position counters and stage valids and
// loads curve_level 1, grid_side 2, cell_side 1.
`default_nettype none

module hilbert_block_scatter_addr (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // configuration write port
  input  wire logic                               cfg_we,
  input  wire logic [hbsa_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [hbsa_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
  // input stream
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [hbsa_pkg::BYTE_BITS-1:0]     in_tdata,   // data_byte[7:0]
  // result stream
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // out_byte[7:0], grid_address[31:8], grid_x[43:32], grid_y[55:44]
  output logic [hbsa_pkg::OUT_DATA_BITS-1:0]      out_tdata,
  output logic                                    out_tlast   // frame_last
);
  import hbsa_pkg::*;

  logic [LEVEL_BITS-1:0] curve_level_r;
  logic [SIDE_BITS-1:0]  grid_side_r;
  logic [SIDE_BITS-1:0]  cell_side_r;
  cfg_eff_t              cfg;
  logic                  walk_valid, walk_ready;
  walk_t                 walk;
  logic                  place_valid, place_ready;
  place_t                place;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      curve_level_r <= LEVEL_BITS'(1);
      grid_side_r   <= SIDE_BITS'(2);
      cell_side_r   <= SIDE_BITS'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CURVE_LEVEL: curve_level_r <= cfg_wdata[LEVEL_BITS-1:0];
        CFG_GRID_SIDE:   grid_side_r   <= cfg_wdata[SIDE_BITS-1:0];
        CFG_CELL_SIDE:   cell_side_r   <= cfg_wdata[SIDE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // clamped level and cell side, cell count
  always_comb begin
    if (curve_level_r == '0) begin
      cfg.level = LEVEL_BITS'(1);
    end else if (curve_level_r > LEVEL_MAX) begin
      cfg.level = LEVEL_MAX;
    end else begin
      cfg.level = curve_level_r;
    end
    if (cell_side_r == '0) begin
      cfg.cell_side = SIDE_BITS'(1);
    end else if (cell_side_r > SIDE_MAX) begin
      cfg.cell_side = SIDE_MAX;
    end else begin
      cfg.cell_side = cell_side_r;
    end
    cfg.cells     = CELL_CNT_BITS'(1) << {cfg.level, 1'b0};
    cfg.grid_side = grid_side_r;
  end

  hbsa_walk u_walk (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_data    (in_tdata),
    .walk_valid (walk_valid),
    .walk_ready (walk_ready),
    .walk       (walk)
  );

  hbsa_place u_place (
    .clk         (clk),
    .rst_n       (rst_n),
    .cell_side   (cfg.cell_side),
    .walk_valid  (walk_valid),
    .walk_ready  (walk_ready),
    .walk        (walk),
    .place_valid (place_valid),
    .place_ready (place_ready),
    .place       (place)
  );

  hbsa_addr u_addr (
    .clk         (clk),
    .rst_n       (rst_n),
    .grid_side   (cfg.grid_side),
    .place_valid (place_valid),
    .place_ready (place_ready),
    .place       (place),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_data    (out_tdata),
    .out_last    (out_tlast)
  );

`ifndef SYNTHESIS
  // an empty output stage never blocks the input
  assert property (@(posedge clk) disable iff (!rst_n) !out_tvalid |-> in_tready)
    else $error("input stalled with empty output stage");

  // an accepted item always lands in the first stage
  assert property (@(posedge clk) disable iff (!rst_n) (in_tvalid && in_tready) |=> walk_valid)
    else $error("accepted item lost at first stage");

  // the first stage is never stalled while the stage after it sits empty
  assert property (@(posedge clk) disable iff (!rst_n)
                   (walk_valid && !place_valid) |-> walk_ready)
    else $error("first stage stalled behind empty stage");
`endif

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// testbench for the hilbert scatter address block: directed table, then random phases
`timescale 1ns / 100ps

module tb;
  import hbsa_pkg::*;

  // unused register index, writes to it must change nothing
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;
  localparam int unsigned COORD_MASK = (1 << COORD_BITS) - 1;
  localparam int unsigned SIDE_LIMIT = 1 << COORD_BITS;
  localparam int          RANDOM_ITEMS = 450;

  // one placed byte as it leaves the block
  typedef struct packed {
    logic [BYTE_BITS-1:0]  data;
    logic [ADDR_BITS-1:0]  addr;
    logic [COORD_BITS-1:0] gx;
    logic [COORD_BITS-1:0] gy;
    logic                  last;
  } placement_t;

  typedef struct packed {
    logic [15:0] cx;
    logic [15:0] cy;
  } cell_pos_t;

  typedef enum logic [1:0] {ROW_WRITE, ROW_BYTE, ROW_BYTE_KNOWN} row_kind_t;

  typedef struct packed {
    row_kind_t                kind;
    logic [CFG_IDX_BITS-1:0]  reg_idx;
    logic [CFG_DATA_BITS-1:0] value;
    placement_t               known;
  } stim_row_t;

  logic                     clk        = 1'b0;
  logic                     rst_n      = 1'b0;
  logic                     cfg_we     = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index  = '0;
  logic [CFG_DATA_BITS-1:0] cfg_wdata  = '0;
  logic                     in_tvalid  = 1'b0;
  logic                     in_tready;
  logic [BYTE_BITS-1:0]     in_tdata   = '0;
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] out_tdata;
  logic                     out_tlast;

  // shadow registers and position counters of the predictor
  logic [LEVEL_BITS-1:0]    level_reg;
  logic [SIDE_BITS-1:0]     grid_reg;
  logic [SIDE_BITS-1:0]     cell_reg;
  int unsigned              cell_cnt;
  int unsigned              row_cnt;
  int unsigned              col_cnt;

  placement_t               placement_q[$];
  int                       error_count  = 0;
  int                       bytes_sent   = 0;
  int                       results_seen = 0;
  int                       frames_seen  = 0;
  int                       writes_done  = 0;
  int                       burst_left   = 0;

  stim_row_t                rows[31];

  hilbert_block_scatter_addr i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // 8 ns clock
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // hilbert index to cell position, first step along +y
  function automatic cell_pos_t hilbert_cell(input int unsigned lvl, input int unsigned d);
    int unsigned px;
    int unsigned py;
    int unsigned t;
    int unsigned s;
    int unsigned qx;
    int unsigned qy;
    int unsigned swp;
    cell_pos_t   p;
    px = 0;
    py = 0;
    t  = d;
    for (int unsigned i = 0; i < lvl; i++) begin
      s  = 1 << i;
      qx = (t >> 1) & 1;
      qy = (t ^ qx) & 1;
      if (qy == 0) begin
        if (qx == 1) begin
          px = s - 1 - px;
          py = s - 1 - py;
        end
        swp = px;
        px  = py;
        py  = swp;
      end
      px = px + s * qx;
      py = py + s * qy;
      t  = t >> 2;
    end
    p.cx = px[15:0];
    p.cy = py[15:0];
    return p;
  endfunction

  // placement of the next byte, and the counter advance behind it
  function automatic placement_t next_placement(input logic [BYTE_BITS-1:0] b);
    int unsigned lvl;
    int unsigned side;
    int unsigned cells;
    int unsigned gx;
    int unsigned gy;
    int unsigned addr;
    cell_pos_t   pos;
    placement_t  r;
    lvl = level_reg;
    if (lvl < 1) lvl = 1;
    if (lvl > MAX_LEVEL) lvl = MAX_LEVEL;
    side = cell_reg;
    if (side < 1) side = 1;
    if (side > SIDE_LIMIT) side = SIDE_LIMIT;
    cells = 1 << (2 * lvl);
    pos   = hilbert_cell(lvl, cell_cnt & (cells - 1));
    gx    = (pos.cx * side + col_cnt) & COORD_MASK;
    gy    = (pos.cy * side + row_cnt) & COORD_MASK;
    addr  = gy * grid_reg + gx;
    r.data = b;
    r.addr = addr[ADDR_BITS-1:0];
    r.gx   = gx[COORD_BITS-1:0];
    r.gy   = gy[COORD_BITS-1:0];
    r.last = 1'b0;
    // column, then row, then cell
    if (col_cnt + 1 >= side) begin
      col_cnt = 0;
      if (row_cnt + 1 >= side) begin
        row_cnt = 0;
        if (cell_cnt + 1 >= cells) begin
          cell_cnt = 0;
          r.last   = 1'b1;
        end else begin
          cell_cnt = cell_cnt + 1;
        end
      end else begin
        row_cnt = row_cnt + 1;
      end
    end else begin
      col_cnt = col_cnt + 1;
    end
    return r;
  endfunction

  // register write, called at a falling edge with the block idle
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(posedge clk);
    case (idx)
      CFG_CURVE_LEVEL: level_reg = val[LEVEL_BITS-1:0];
      CFG_GRID_SIDE:   grid_reg  = val;
      CFG_CELL_SIDE:   cell_reg  = val;
      default: ;
    endcase
    writes_done++;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // one input item in bursts with random gaps, called at a falling edge
  task automatic send_item(input logic [BYTE_BITS-1:0] b, input logic use_known,
                           input placement_t known);
    int         gap;
    placement_t p;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_tvalid = 1'b1;
    in_tdata  = b;
    do @(posedge clk); while (!in_tready);
    p = next_placement(b);
    placement_q.push_back(use_known ? known : p);
    bytes_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  // hold the sender until every result is back
  task automatic drain_results();
    in_tvalid  = 1'b0;
    burst_left = 0;
    while (placement_q.size() != 0) @(negedge clk);
  endtask

  // receiver: phases of always ready, random ready and long stalls
  int rx_mode  = 0;
  int rx_count = 0;
  int rx_stall = 0;
  always @(negedge clk) begin
    rx_count++;
    if (rx_count % 97 == 0) rx_mode = $urandom_range(0, 2);
    if (rx_stall != 0) begin
      out_tready = 1'b0;
      rx_stall--;
    end else begin
      case (rx_mode)
        0: out_tready = 1'b1;
        1: out_tready = ($urandom_range(0, 3) != 0);
        default: begin
          out_tready = 1'b1;
          if ($urandom_range(0, 15) == 0) rx_stall = $urandom_range(1, 12);
        end
      endcase
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    placement_t want;
    placement_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.data = out_tdata[7:0];
      got.addr = out_tdata[31:8];
      got.gx   = out_tdata[43:32];
      got.gy   = out_tdata[55:44];
      got.last = out_tlast;
      results_seen++;
      if (got.last) frames_seen++;
      if (placement_q.size() == 0) begin
        $display("%0t: unexpected result data %h addr %h x %0d y %0d last %b",
                 $time, got.data, got.addr, got.gx, got.gy, got.last);
        error_count++;
      end else begin
        want = placement_q.pop_front();
        if (got.data !== want.data) begin
          $display("%0t: data exp %h got %h", $time, want.data, got.data);
          error_count++;
        end
        if (got.addr !== want.addr) begin
          $display("%0t: addr exp %h got %h", $time, want.addr, got.addr);
          error_count++;
        end
        if (got.gx !== want.gx) begin
          $display("%0t: x exp %0d got %0d", $time, want.gx, got.gx);
          error_count++;
        end
        if (got.gy !== want.gy) begin
          $display("%0t: y exp %0d got %0d", $time, want.gy, got.gy);
          error_count++;
        end
        if (got.last !== want.last) begin
          $display("%0t: last exp %b got %b", $time, want.last, got.last);
          error_count++;
        end
      end
    end
  end

  // watchdog
  initial begin
    #2000000;
    $display("tb: errors");
    $finish;
  end

  // main sequence
  initial begin
    int random_items;
    int mode;
    int lvl;
    int side;
    int n;
    random_items = 0;
    level_reg    = 4'd1;
    grid_reg     = 13'd2;
    cell_reg     = 13'd1;
    cell_cnt     = 0;
    row_cnt      = 0;
    col_cnt      = 0;

    // directed table; known rows are the first frames at reset sizes
    rows = '{
      '{ROW_BYTE_KNOWN, 2'd0, 13'h000, '{8'h00, 24'd0, 12'd0, 12'd0, 1'b0}},
      '{ROW_BYTE_KNOWN, 2'd0, 13'h0ff, '{8'hff, 24'd2, 12'd0, 12'd1, 1'b0}},
      '{ROW_BYTE_KNOWN, 2'd0, 13'h055, '{8'h55, 24'd3, 12'd1, 12'd1, 1'b0}},
      '{ROW_BYTE_KNOWN, 2'd0, 13'h0aa, '{8'haa, 24'd1, 12'd1, 12'd0, 1'b1}},
      // level zero counts as one
      '{ROW_WRITE,      CFG_CURVE_LEVEL, 13'd0, '0},
      '{ROW_BYTE_KNOWN, 2'd0, 13'h001, '{8'h01, 24'd0, 12'd0, 12'd0, 1'b0}},
      '{ROW_BYTE_KNOWN, 2'd0, 13'h080, '{8'h80, 24'd2, 12'd0, 12'd1, 1'b0}},
      // mid-frame change to oversized level and sides, coordinates and address wrap
      '{ROW_WRITE,      CFG_CURVE_LEVEL, 13'd15, '0},
      '{ROW_WRITE,      CFG_GRID_SIDE,   13'd8191, '0},
      '{ROW_WRITE,      CFG_CELL_SIDE,   13'd8191, '0},
      '{ROW_BYTE,       2'd0, 13'h0ff, '0},
      '{ROW_BYTE,       2'd0, 13'h000, '0},
      '{ROW_BYTE,       2'd0, 13'h07f, '0},
      // cell side zero counts as one
      '{ROW_WRITE,      CFG_CELL_SIDE,   13'd0, '0},
      '{ROW_BYTE,       2'd0, 13'h03c, '0},
      '{ROW_BYTE,       2'd0, 13'h0c3, '0},
      '{ROW_BYTE,       2'd0, 13'h00f, '0},
      '{ROW_WRITE,      CFG_CELL_SIDE,   13'd16, '0},
      '{ROW_WRITE,      CFG_GRID_SIDE,   13'd4096, '0},
      '{ROW_WRITE,      CFG_CURVE_LEVEL, 13'd8, '0},
      '{ROW_BYTE,       2'd0, 13'h0f0, '0},
      '{ROW_BYTE,       2'd0, 13'h05a, '0},
      '{ROW_BYTE,       2'd0, 13'h0a5, '0},
      // unused index is ignored
      '{ROW_WRITE,      CFG_UNUSED,      13'd8191, '0},
      // back to the smallest frame: counters past the limit wrap with frame end
      '{ROW_WRITE,      CFG_CURVE_LEVEL, 13'd1, '0},
      '{ROW_WRITE,      CFG_GRID_SIDE,   13'd2, '0},
      '{ROW_WRITE,      CFG_CELL_SIDE,   13'd1, '0},
      '{ROW_BYTE,       2'd0, 13'h011, '0},
      '{ROW_BYTE,       2'd0, 13'h022, '0},
      '{ROW_BYTE,       2'd0, 13'h033, '0},
      '{ROW_BYTE,       2'd0, 13'h044, '0}
    };

    // reset
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (rows[i]) begin
      case (rows[i].kind)
        ROW_WRITE: begin
          drain_results();
          write_reg(rows[i].reg_idx, rows[i].value);
        end
        ROW_BYTE:       send_item(rows[i].value[7:0], 1'b0, '0);
        ROW_BYTE_KNOWN: send_item(rows[i].value[7:0], 1'b1, rows[i].known);
        default: ;
      endcase
    end

    // random phases, mostly small consistent frames so that frames end often
    while (random_items < RANDOM_ITEMS) begin
      drain_results();
      mode = $urandom_range(0, 9);
      if (mode < 7) begin
        lvl  = ($urandom_range(0, 3) == 0) ? 2 : 1;
        side = $urandom_range(1, 2);
        write_reg(CFG_CURVE_LEVEL, CFG_DATA_BITS'(lvl));
        write_reg(CFG_CELL_SIDE, CFG_DATA_BITS'(side));
        write_reg(CFG_GRID_SIDE, CFG_DATA_BITS'(side << lvl));
      end else if (mode < 9) begin
        write_reg(CFG_CURVE_LEVEL, CFG_DATA_BITS'($urandom));
        write_reg(CFG_GRID_SIDE, CFG_DATA_BITS'($urandom));
        write_reg(CFG_CELL_SIDE, CFG_DATA_BITS'($urandom));
      end else begin
        write_reg(CFG_IDX_BITS'($urandom), CFG_DATA_BITS'($urandom));
      end
      n = $urandom_range(8, 60);
      repeat (n) begin
        send_item(BYTE_BITS'($urandom), 1'b0, '0);
        random_items++;
      end
    end

    drain_results();
    repeat (8) @(negedge clk);

    $display("tb: %0d bytes placed, %0d results checked, %0d frame ends",
             bytes_sent, results_seen, frames_seen);
    $display("tb: %0d register writes, %0d mismatches", writes_done, error_count);
    if (error_count == 0 && placement_q.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
